>>> src/sts_pkg.sv
`timescale 1ns / 1ps

package sts_pkg;

  localparam int unsigned LEAVES      = 1024;
  localparam int unsigned LEAF_BITS   = $clog2(LEAVES);
  localparam int unsigned INNER_NODES = LEAVES - 1;
  localparam int unsigned TREE_NODES  = 2 * LEAVES - 1;
  localparam int unsigned NODE_BITS   = LEAF_BITS + 1;
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned RANDOM_BITS = 16;
  localparam int unsigned SUM_BITS    = WEIGHT_BITS + LEAF_BITS;

  localparam int unsigned IN_DATA_BITS  = 48;
  localparam int unsigned OUT_DATA_BITS = 40;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Request from the sequencer to the node memory.
  typedef struct packed {
    logic                 we;
    logic [NODE_BITS-1:0] waddr;
    logic [SUM_BITS-1:0]  wdata;
    logic                 re;
    logic [NODE_BITS-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                 was_sample;
    logic [LEAF_BITS-1:0] sampled_index;
    logic                 tree_empty;
    logic [SUM_BITS-1:0]  total_weight;
  } result_t;

endpackage

>>> src/sum_tree_weighted_sampler_top.sv
`timescale 1ns / 1ps

// Weighted sampler over a binary sum tree of 1024 leaf weights.
// Requests come in on the s_axis channel: tuser selects a weight write (0)
// or a draw (1); tdata carries the leaf index, the weight and a Q0.16 random
// fraction. Each request gives exactly one result on the m_axis channel:
// tuser flags a draw, tdata carries the drawn leaf, an empty-tree flag and
// the root total after the request.
// A draw scales the fraction by the total, walks down ten levels of the
// node memory, then zeroes the drawn leaf and corrects its ten ancestors.
// The node memory, with one read and one write port and a registered read,
// sets the pace of each request. One request is in work at a time.
// After reset the node memory is swept to zero, one node per cycle, over all
// 2047 nodes; s_axis_tready stays low until the sweep has finished.
// A result waits in the output register while the receiver stalls; the next
// request is taken meanwhile but its result waits until the register frees.
module sum_tree_weighted_sampler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // leaf_index [9:0], weight [25:10], random_fraction [41:26], zeros above
  input  logic [47:0] s_axis_tdata,
  // operation [0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sampled_index [9:0], tree_empty [10], total_weight [36:11], zeros above
  output logic [39:0] m_axis_tdata,
  // was_sample [0]
  output logic [0:0]  m_axis_tuser
);
  import sts_pkg::*;

  mem_req_t            mem_req;
  logic [SUM_BITS-1:0] mem_rdata;
  result_t             result;
  logic                done;
  logic                out_free;
  logic                m_valid_q;
  result_t             m_res_q;

  assign out_free = !m_valid_q || m_axis_tready;

  sts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .op_i        (s_axis_tuser[0]),
    .leaf_i      (s_axis_tdata[LEAF_BITS-1:0]),
    .weight_i    (s_axis_tdata[10 +: WEIGHT_BITS]),
    .random_i    (s_axis_tdata[26 +: RANDOM_BITS]),
    .out_free_i  (out_free),
    .done_o      (done),
    .result_o    (result),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  sts_node_ram #(
    .DEPTH     (TREE_NODES),
    .ADDR_BITS (NODE_BITS),
    .DATA_BITS (SUM_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      m_res_q <= result;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.was_sample;
  assign m_axis_tdata  = {3'b000, m_res_q.total_weight, m_res_q.tree_empty,
                          m_res_q.sampled_index};

endmodule

>>> src/sts_node_ram.sv
`timescale 1ns / 1ps

module sts_node_ram #(
  parameter int unsigned DEPTH      = 2047,
  parameter int unsigned ADDR_BITS  = 11,
  parameter int unsigned DATA_BITS  = 26
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/sts_ctrl.sv
`timescale 1ns / 1ps

module sts_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic                          op_i,
  input  logic [sts_pkg::LEAF_BITS-1:0]   leaf_i,
  input  logic [sts_pkg::WEIGHT_BITS-1:0] weight_i,
  input  logic [sts_pkg::RANDOM_BITS-1:0] random_i,
  input  logic                          out_free_i,
  output logic                          done_o,
  output sts_pkg::result_t              result_o,
  output sts_pkg::mem_req_t             mem_req_o,
  input  logic [sts_pkg::SUM_BITS-1:0]    mem_rdata_i
);
  import sts_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DESC  = 3'd2;
  localparam logic [2:0] ST_LEAF  = 3'd3;
  localparam logic [2:0] ST_UP    = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  localparam logic [NODE_BITS-1:0] LAST_NODE  = NODE_BITS'(TREE_NODES - 1);
  localparam logic [NODE_BITS-1:0] FIRST_LEAF = NODE_BITS'(INNER_NODES);

  logic [2:0]             state_q, state_d;
  logic [NODE_BITS-1:0]   node_q, node_d;
  logic [SUM_BITS-1:0]    x_q, x_d;
  logic [SUM_BITS-1:0]    total_q, total_d;
  logic [SUM_BITS-1:0]    delta_q, delta_d;
  logic [LEAF_BITS-1:0]   pick_q, pick_d;
  logic                   op_q, op_d;
  logic                   empty_q, empty_d;
  logic [WEIGHT_BITS-1:0] weight_q, weight_d;

  logic                          accept;
  logic [RANDOM_BITS+SUM_BITS-1:0] product;
  logic [NODE_BITS-1:0]          left_node, right_node, next_node, next_left;
  logic [NODE_BITS-1:0]          node_m1, parent;
  logic                          go_right;
  logic [SUM_BITS-1:0]           new_leaf;
  mem_req_t                      req;

  assign accept  = req_valid_i && req_ready_o;
  assign product = (RANDOM_BITS+SUM_BITS)'(random_i) * (RANDOM_BITS+SUM_BITS)'(total_q);

  assign left_node  = {node_q[NODE_BITS-2:0], 1'b1};
  assign right_node = left_node + NODE_BITS'(1);
  assign go_right   = x_q >= mem_rdata_i;
  assign next_node  = go_right ? right_node : left_node;
  assign next_left  = {next_node[NODE_BITS-2:0], 1'b1};
  assign node_m1    = node_q - NODE_BITS'(1);
  assign parent     = {1'b0, node_m1[NODE_BITS-1:1]};
  assign new_leaf   = (op_q == OP_WRITE) ? SUM_BITS'(weight_q) : '0;

  always_comb begin
    state_d  = state_q;
    node_d   = node_q;
    x_d      = x_q;
    total_d  = total_q;
    delta_d  = delta_q;
    pick_d   = pick_q;
    op_d     = op_q;
    empty_d  = empty_q;
    weight_d = weight_q;
    req      = '0;
    done_o   = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = node_q;
        node_d    = node_q + NODE_BITS'(1);
        if (node_q == LAST_NODE) begin
          node_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_d     = op_i;
          weight_d = weight_i;
          empty_d  = 1'b0;
          pick_d   = '0;
          x_d      = product[RANDOM_BITS +: SUM_BITS];
          if (op_i == OP_WRITE) begin
            node_d    = FIRST_LEAF + NODE_BITS'(leaf_i);
            req.re    = 1'b1;
            req.raddr = FIRST_LEAF + NODE_BITS'(leaf_i);
            state_d   = ST_LEAF;
          end else if (total_q == '0) begin
            // Nothing left to draw: report and leave the tree alone.
            empty_d = 1'b1;
            state_d = ST_FIN;
          end else begin
            node_d    = '0;
            req.re    = 1'b1;
            req.raddr = NODE_BITS'(1);
            state_d   = ST_DESC;
          end
        end
      end
      ST_DESC: begin
        // The read data is the left child sum of the current node.
        if (go_right) begin
          x_d = x_q - mem_rdata_i;
        end
        node_d = next_node;
        req.re = 1'b1;
        if (next_node >= FIRST_LEAF) begin
          req.raddr = next_node;
          state_d   = ST_LEAF;
        end else begin
          req.raddr = next_left;
        end
      end
      ST_LEAF: begin
        pick_d    = LEAF_BITS'(node_q - FIRST_LEAF);
        delta_d   = new_leaf - mem_rdata_i;
        total_d   = total_q + (new_leaf - mem_rdata_i);
        req.we    = 1'b1;
        req.waddr = node_q;
        req.wdata = new_leaf;
        req.re    = 1'b1;
        req.raddr = parent;
        node_d    = parent;
        state_d   = ST_UP;
      end
      ST_UP: begin
        // Every ancestor moves by the same amount as the leaf did.
        req.we    = 1'b1;
        req.waddr = node_q;
        req.wdata = mem_rdata_i + delta_q;
        if (node_q == '0) begin
          state_d = ST_FIN;
        end else begin
          req.re    = 1'b1;
          req.raddr = parent;
          node_d    = parent;
        end
      end
      ST_FIN: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      node_q  <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      node_q  <= node_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    delta_q  <= delta_d;
    pick_q   <= pick_d;
    op_q     <= op_d;
    empty_q  <= empty_d;
    weight_q <= weight_d;
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign mem_req_o   = req;

  assign result_o.was_sample    = op_q;
  assign result_o.sampled_index = (op_q == OP_SAMPLE && !empty_q) ? pick_q : '0;
  assign result_o.tree_empty    = empty_q;
  assign result_o.total_weight  = total_q;

`ifndef ASSERT_OFF
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_FIN) |-> !req.we)
    else $error("node memory written outside an update");

  a_no_same_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.we && req.re) |-> (req.waddr != req.raddr))
    else $error("read and write of the same node in one cycle");

  a_leaf_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEAF && op_q == OP_SAMPLE) |-> (mem_rdata_i != '0))
    else $error("descent ended on a leaf of zero weight");

  a_root_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UP && node_q == '0) |-> (mem_rdata_i + delta_q == total_q))
    else $error("root sum differs from the running total");

  a_done_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after a result");
`endif

endmodule
